### design/gsl_pkg.sv
// Shared types and constants for the gapped sorted lower-bound core.
`default_nettype none
package gsl_pkg;

  localparam int SLOT_IDX_W = 10;
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 11;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### design/gapped_sorted_lower_bound_core.sv
// Top level of the gapped sorted lower-bound core: slot table, scan control, result register.
// A write transfer stores value into slot slot_index (zero empties the slot, an index at or
// beyond TABLE_DEPTH is dropped) and yields no result. A search transfer scans
// the table memory one slot per cycle from index 0 and returns the first nonzero slot whose
// signed value is at least the key, or TABLE_DEPTH when none is found (position is 11 bits,
// so larger depths lose the high bits). A search holds in_stall high until its result is
// loaded into the result register, including any wait for that register to drain. The
// scan length is set by the single read port of the table memory. After reset the block
// clears every slot of the table in one pass, during which in_stall is high. The
// result register lets a new transfer be taken while the previous result is still pending.
`default_nettype none
module gapped_sorted_lower_bound_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          cmd,
  input  wire logic [gsl_pkg::SLOT_IDX_W-1:0] slot_index,
  input  wire logic [gsl_pkg::VALUE_W-1:0]    value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [gsl_pkg::POS_W-1:0]      position
);
  import gsl_pkg::*;

  localparam int          AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST  = AW'(TABLE_DEPTH - 1);

  state_t state, state_next;

  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      issue_addr;
  logic               issue_more;
  logic               rd_vld;
  logic [AW-1:0]      rd_idx;
  logic [VALUE_W-1:0] key;
  logic [POS_W-1:0]   res_pos;

  logic               in_xfer;
  logic               out_free;
  logic [31:0]        idx32;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [VALUE_W-1:0] rd_data;
  logic               hit;
  logic               miss_end;
  logic [31:0]        rd_idx32;
  logic [POS_W-1:0]   scan_pos;
  logic               load_out;
  logic [POS_W-1:0]   load_pos;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign idx32    = 32'(slot_index);
  assign rd_idx32 = 32'(rd_idx);

  assign hit      = rd_vld && (rd_data != '0) && ($signed(rd_data) >= $signed(key));
  assign miss_end = rd_vld && (rd_idx == LAST);
  assign scan_pos = hit ? rd_idx32[POS_W-1:0] : DEPTH32[POS_W-1:0];

  // Table writes come from the clearing pass or from a write transfer.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (in_xfer && (cmd == CMD_WRITE) && (idx32 < DEPTH32)) begin
      mem_we    = 1'b1;
      mem_waddr = idx32[AW-1:0];
      mem_wdata = value;
    end
  end

  gsl_slot_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (issue_addr),
    .rdata (rd_data)
  );

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    load_pos   = res_pos;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer && (cmd == CMD_SEARCH)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || miss_end) begin
          load_pos = scan_pos;
          if (out_free) begin
            load_out   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      issue_addr <= '0;
      issue_more <= 1'b0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (in_xfer && (cmd == CMD_SEARCH)) begin
        issue_addr <= '0;
        issue_more <= 1'b1;
        rd_vld     <= 1'b0;
      end else if (state == ST_SCAN && !(hit || miss_end)) begin
        // Advance the read pointer; the read data arrives in the cycle after its address.
        rd_vld <= issue_more;
        if (issue_more) begin
          issue_addr <= issue_addr + AW'(1);
          issue_more <= (issue_addr != LAST);
        end
      end else begin
        rd_vld     <= 1'b0;
        issue_more <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (cmd == CMD_SEARCH)) begin
      key <= value;
    end
    if (state == ST_SCAN) begin
      rd_idx <= issue_addr;
    end
    if (state == ST_SCAN && (hit || miss_end)) begin
      res_pos <= scan_pos;
    end
    if (load_out) begin
      position <= load_pos;
    end
  end

`ifndef SYNTHESIS
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (cmd == CMD_WRITE)) |=> !$rose(out_valid))
    else $error("write transfer produced a result");

  a_search_holds_input: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (cmd == CMD_SEARCH)) |=> in_stall)
    else $error("search transfer did not hold the input side");

  a_read_lag: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && rd_vld && issue_more) |-> (issue_addr == rd_idx + AW'(1)))
    else $error("read pointer out of step with checked slot");

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((TABLE_DEPTH >= 2048) || (32'(position) <= DEPTH32)))
    else $error("position beyond table depth");
`endif

endmodule
`default_nettype wire

### design/gsl_slot_ram.sv
// Slot table memory: one write port, one read port, registered read data.
`default_nettype none
module gsl_slot_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [gsl_pkg::VALUE_W-1:0] wdata,
  input  wire logic [AW-1:0]              raddr,
  output logic      [gsl_pkg::VALUE_W-1:0] rdata
);
  import gsl_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
